### hw/rtl/ncp_pkg.sv
// Shared types, constants and helpers of the next command predictor.
package ncp_pkg;

    localparam int TableEntriesDefault = 32;
    localparam int KeyBytesDefault     = 32;
    localparam int KeyWidth            = 248;
    localparam int CountWidth          = 32;

    typedef enum logic [2:0] {
        ST_COUNTED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_IGNORED   = 3'd2,
        ST_PREDICTED = 3'd3,
        ST_NOMATCH   = 3'd4,
        ST_NOPREV    = 3'd5
    } status_t;

    typedef enum logic {
        REQ_LEARN   = 1'b0,
        REQ_PREDICT = 1'b1
    } req_t;

    typedef struct packed {
        logic        req_type;
        logic [63:0] from_w0;
        logic [63:0] from_w1;
        logic [63:0] from_w2;
        logic [55:0] from_w3;
        logic [63:0] to_w0;
        logic [63:0] to_w1;
        logic [63:0] to_w2;
        logic [55:0] to_w3;
    } ncp_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] next_w0;
        logic [63:0] next_w1;
        logic [63:0] next_w2;
        logic [55:0] next_w3;
        logic [31:0] hit_count;
    } ncp_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NORM,
        S_READ,
        S_CHECK,
        S_UPDATE,
        S_DONE
    } ncp_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic norm;
        logic scan_clear;
        logic scan_read;
        logic scan_check;
        logic update;
        logic finish;
    } ncp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic key_empty;
        logic scan_last;
        logic hit_found;
        logic is_predict;
    } ncp_stat_t;

    // Keeps bytes before the first zero byte and below key_bytes-1.
    function automatic logic [KeyWidth-1:0] norm_key(input logic [KeyWidth-1:0] k,
                                                     input int key_bytes);
        logic [KeyWidth-1:0] r;
        logic                live;
        r    = '0;
        live = 1'b1;
        for (int i = 0; i < KeyWidth/8; i++) begin
            if (i >= key_bytes - 1 || k[i*8 +: 8] == 8'd0)
                live = 1'b0;
            if (live)
                r[i*8 +: 8] = k[i*8 +: 8];
        end
        return r;
    endfunction

endpackage

### hw/rtl/next_command_predictor_core.sv
// Top level of the next command predictor.
// A request beat is taken when start is high and busy is low; busy then stays
// high until the result has been written. The length of a request is set by
// the sequential scan, which walks the used table entries one at a time,
// reading each from the pair memory and comparing it against the normalized
// keys. A learn request stops at the first matching pair; an empty from-key
// skips the scan entirely. The result beat appears for exactly one cycle with
// done high, in the first cycle in which busy is low again, and the receiver
// cannot stall it, so it must capture every beat.
// The pair table holds no reset state beyond its fill count.
module next_command_predictor_core
    import ncp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int KEY_BYTES     = KeyBytesDefault
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ncp_req_t req,
    output logic     busy,
    output logic     done,
    output ncp_rsp_t rsp
);

    ncp_cmd_t  cmd;
    ncp_stat_t stat;

    ncp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ncp_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .KEY_BYTES     (KEY_BYTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (done),
        .result       (rsp)
    );

endmodule

### hw/rtl/ncp_ctrl.sv
// Controller state machine of the next command predictor.
module ncp_ctrl
    import ncp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  ncp_stat_t stat,
    output ncp_cmd_t  cmd,
    output logic      busy
);

    ncp_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (start) state_next = S_NORM;
            S_NORM:   state_next = stat.key_empty ? S_DONE : S_READ;
            S_READ:   state_next = stat.scan_last ? S_UPDATE : S_CHECK;
            S_CHECK:
            begin
                if (stat.hit_found && !stat.is_predict)
                    state_next = S_UPDATE;
                else
                    state_next = S_READ;
            end
            S_UPDATE: state_next = S_DONE;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:   cmd.load = start;
            S_NORM:
            begin
                cmd.norm       = 1'b1;
                cmd.scan_clear = 1'b1;
            end
            S_READ:   cmd.scan_read = 1'b1;
            S_CHECK:  cmd.scan_check = 1'b1;
            S_UPDATE: cmd.update = 1'b1;
            S_DONE:   cmd.finish = 1'b1;
            default:  cmd = '0;
        endcase
    end

endmodule

### hw/rtl/ncp_datapath.sv
// Datapath of the next command predictor: key registers, pair table and scan.
module ncp_datapath
    import ncp_pkg::*;
#(
    parameter int TABLE_ENTRIES = TableEntriesDefault,
    parameter int KEY_BYTES     = KeyBytesDefault
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  ncp_req_t  req,
    input  ncp_cmd_t  cmd,
    output ncp_stat_t stat,
    output logic      result_valid,
    output ncp_rsp_t  result
);

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);

    logic [KeyWidth-1:0]   from_mem [TABLE_ENTRIES];
    logic [KeyWidth-1:0]   to_mem   [TABLE_ENTRIES];
    logic [CountWidth-1:0] cnt_mem  [TABLE_ENTRIES];

    logic                  predict_reg;
    logic [KeyWidth-1:0]   fk_reg, tk_reg;
    logic [CntW-1:0]       used_reg;
    logic [CntW-1:0]       scan_reg;
    logic [KeyWidth-1:0]   rd_from_reg, rd_to_reg;
    logic [CountWidth-1:0] rd_cnt_reg;
    logic                  found_reg;
    logic [IdxW-1:0]       best_idx_reg;
    logic [CountWidth-1:0] best_cnt_reg;
    logic [KeyWidth-1:0]   best_to_reg;
    logic                  hit_reg;
    logic [IdxW-1:0]       rd_idx_reg;
    logic                  result_valid_reg;
    ncp_rsp_t              result_reg;
    ncp_rsp_t              result_next;

    // Set when the current learn request took a new entry.
    logic inserted_reg;

    logic from_eq, to_eq, hit_now;
    logic [IdxW-1:0] scan_idx;

    assign scan_idx = scan_reg[IdxW-1:0];
    assign from_eq  = (rd_from_reg == fk_reg);
    assign to_eq    = (rd_to_reg == tk_reg);
    assign hit_now  = predict_reg ? (from_eq && rd_cnt_reg > best_cnt_reg)
                                  : (from_eq && to_eq);

    assign stat.key_empty  = (fk_reg[7:0] == 8'd0);
    assign stat.scan_last  = (scan_reg >= used_reg);
    assign stat.hit_found  = hit_now;
    assign stat.is_predict = predict_reg;

    always_comb
    begin
        result_next = '0;
        if (fk_reg[7:0] == 8'd0)
            result_next.status = predict_reg ? ST_NOPREV : ST_IGNORED;
        else if (predict_reg)
        begin
            if (found_reg)
            begin
                result_next.status    = ST_PREDICTED;
                result_next.next_w0   = best_to_reg[63:0];
                result_next.next_w1   = best_to_reg[127:64];
                result_next.next_w2   = best_to_reg[191:128];
                result_next.next_w3   = best_to_reg[247:192];
                result_next.hit_count = best_cnt_reg;
            end
            else
                result_next.status = ST_NOMATCH;
        end
        else if (hit_reg)
        begin
            result_next.status    = ST_COUNTED;
            result_next.hit_count = best_cnt_reg;
        end
        else if (used_reg < CntW'(TABLE_ENTRIES) || inserted_reg)
        begin
            result_next.status    = ST_INSERTED;
            result_next.hit_count = CountWidth'(1);
        end
        else
            result_next.status = ST_IGNORED;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            predict_reg <= req.req_type;
            fk_reg <= {req.from_w3, req.from_w2, req.from_w1, req.from_w0};
            tk_reg <= {req.to_w3, req.to_w2, req.to_w1, req.to_w0};
        end
        if (cmd.norm)
        begin
            fk_reg <= norm_key(fk_reg, KEY_BYTES);
            tk_reg <= norm_key(tk_reg, KEY_BYTES);
        end
        if (cmd.scan_clear)
        begin
            scan_reg     <= '0;
            found_reg    <= 1'b0;
            hit_reg      <= 1'b0;
            best_cnt_reg <= '0;
        end
        if (cmd.scan_read)
        begin
            rd_from_reg <= from_mem[scan_idx];
            rd_to_reg   <= to_mem[scan_idx];
            rd_cnt_reg  <= cnt_mem[scan_idx];
            rd_idx_reg  <= scan_idx;
            scan_reg    <= scan_reg + 1'b1;
        end
        if (cmd.scan_check && hit_now)
        begin
            found_reg    <= 1'b1;
            hit_reg      <= 1'b1;
            best_idx_reg <= rd_idx_reg;
            best_cnt_reg <= rd_cnt_reg;
            best_to_reg  <= rd_to_reg;
        end
        if (cmd.update && !predict_reg)
        begin
            if (hit_reg)
            begin
                if (best_cnt_reg != '1)
                begin
                    cnt_mem[best_idx_reg] <= best_cnt_reg + 1'b1;
                    best_cnt_reg          <= best_cnt_reg + 1'b1;
                end
            end
            else if (used_reg < CntW'(TABLE_ENTRIES))
            begin
                from_mem[used_reg[IdxW-1:0]] <= fk_reg;
                to_mem[used_reg[IdxW-1:0]]   <= tk_reg;
                cnt_mem[used_reg[IdxW-1:0]]  <= CountWidth'(1);
            end
        end
        if (cmd.finish)
            result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg         <= '0;
            inserted_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= cmd.finish;
            if (cmd.load)
                inserted_reg <= 1'b0;
            if (cmd.update && !predict_reg && !hit_reg && used_reg < CntW'(TABLE_ENTRIES))
            begin
                used_reg     <= used_reg + 1'b1;
                inserted_reg <= 1'b1;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
